// ===== hdl/gfb_pkg.sv =====
// ----------------------------------------------------------------------------
// gfb_pkg: shared types, constants and round function
// Round count, key reset values, S-boxes and the item type that moves
// from cell to cell along the round chain.
// ----------------------------------------------------------------------------
package gfb_pkg;

   localparam int ROUND_COUNT    = 32;
   localparam int FORWARD_ROUNDS = 24;
   localparam int ROT_AMOUNT     = 11;
   localparam int KEY_COUNT      = 8;
   localparam int KEY_IDX_WIDTH  = $clog2(KEY_COUNT);
   localparam int WORD_WIDTH     = 32;
   localparam int BLOCK_WIDTH    = 64;
   localparam int CSR_IDX_WIDTH  = 4;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef word_type [KEY_COUNT-1:0] key_array_type;

   // One item in flight between round cells.
   typedef struct packed {
      logic     mode;
      word_type left;
      word_type right;
   } stage_type;

   localparam key_array_type KEY_RESET = '{
      32'h5566_7788, 32'hAABB_CCDD, 32'h1122_3344, 32'hFEDC_BA12,
      32'h9876_5432, 32'h5678_EFEF, 32'hABCD_1234, 32'hFFFF_FFFF
   };

   localparam logic [3:0] SBOX [0:7][0:15] = '{
      '{4'd4,  4'd7,  4'd1,  4'd9,  4'd0,  4'd2,  4'd4,  4'd8,
        4'd6,  4'd3,  4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd10},
      '{4'd12, 4'd6,  4'd11, 4'd2,  4'd10, 4'd4,  4'd7,  4'd5,
        4'd9,  4'd0,  4'd1,  4'd3,  4'd8,  4'd13, 4'd14, 4'd15},
      '{4'd7,  4'd2,  4'd5,  4'd0,  4'd11, 4'd14, 4'd15, 4'd10,
        4'd9,  4'd12, 4'd8,  4'd1,  4'd3,  4'd4,  4'd6,  4'd13},
      '{4'd8,  4'd14, 4'd7,  4'd6,  4'd2,  4'd5,  4'd1,  4'd15,
        4'd4,  4'd0,  4'd11, 4'd10, 4'd13, 4'd9,  4'd12, 4'd3},
      '{4'd15, 4'd6,  4'd9,  4'd11, 4'd3,  4'd12, 4'd4,  4'd2,
        4'd10, 4'd8,  4'd1,  4'd0,  4'd7,  4'd14, 4'd4,  4'd13},
      '{4'd12, 4'd15, 4'd0,  4'd9,  4'd4,  4'd8,  4'd13, 4'd2,
        4'd11, 4'd10, 4'd7,  4'd6,  4'd5,  4'd3,  4'd14, 4'd1},
      '{4'd14, 4'd3,  4'd1,  4'd10, 4'd7,  4'd15, 4'd13, 4'd12,
        4'd0,  4'd2,  4'd11, 4'd4,  4'd8,  4'd9,  4'd6,  4'd5},
      '{4'd6,  4'd8,  4'd15, 4'd4,  4'd10, 4'd7,  4'd12, 4'd1,
        4'd2,  4'd0,  4'd14, 4'd5,  4'd11, 4'd3,  4'd9,  4'd13}
   };

   // Add key, substitute each nibble, rotate left.
   function automatic word_type round_fn(input word_type half, input word_type rk);
      word_type x;
      word_type y;
      x = half + rk;
      for (int n = 0; n < KEY_COUNT; n++) begin
         y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
      end
      return {y[WORD_WIDTH-ROT_AMOUNT-1:0], y[WORD_WIDTH-1:WORD_WIDTH-ROT_AMOUNT]};
   endfunction

endpackage

// ===== hdl/gfb_key_regs.sv =====
// ----------------------------------------------------------------------------
// gfb_key_regs: key word registers
// Eight 32-bit key words loaded through the write port; writes to an
// index past the last word are dropped.
// ----------------------------------------------------------------------------
module gfb_key_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [gfb_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [gfb_pkg::WORD_WIDTH-1:0]    csr_data,
   output gfb_pkg::key_array_type       keys
);
   import gfb_pkg::*;

   key_array_type key_ff;
   key_array_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_write && (csr_index < CSR_IDX_WIDTH'(KEY_COUNT))) begin
         key_in[csr_index[KEY_IDX_WIDTH-1:0]] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   assign keys = key_ff;

endmodule

// ===== hdl/gfb_round_cell.sv =====
// ----------------------------------------------------------------------------
// gfb_round_cell: one Feistel round with its own pipeline register
// Takes an item from the left neighbor, applies one round with the key
// picked by the item's mode, and holds it until the right neighbor takes it.
// ----------------------------------------------------------------------------
module gfb_round_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  gfb_pkg::stage_type  in_data,
   input  gfb_pkg::word_type   enc_key,
   input  gfb_pkg::word_type   dec_key,
   output logic                out_valid,
   input  logic                out_ready,
   output gfb_pkg::stage_type  out_data
);
   import gfb_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   word_type  f_out;

   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      if (in_data.mode == MODE_DECRYPT) begin
         f_out         = round_fn(in_data.left, dec_key);
         data_in.mode  = in_data.mode;
         data_in.left  = in_data.right ^ f_out;
         data_in.right = in_data.left;
      end else begin
         f_out         = round_fn(in_data.right, enc_key);
         data_in.mode  = in_data.mode;
         data_in.left  = in_data.right;
         data_in.right = in_data.left ^ f_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load only when a new item is taken; otherwise hold.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/gost_feistel_block_cipher_top.sv =====
// Each item passes through the pipeline register of every round cell in turn.
// Throughput: one item per cycle; each of the 32 cells is a one-item stage,
// and a stalled output backs up only as far as the cells that are full.
// Reset clears all cell valid bits and loads the key words with their
// default values; the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
// gost_feistel_block_cipher_top: 32-round Feistel block cipher
// Key registers feed a chain of round cells; each cell picks its key word
// for encryption or decryption from its position in the chain.
// ----------------------------------------------------------------------------
module gost_feistel_block_cipher_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gfb_pkg::BLOCK_WIDTH-1:0]    req_block_in,
   input  logic                               req_mode,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gfb_pkg::BLOCK_WIDTH-1:0]    rsp_block_out,
   input  logic                               csr_write,
   input  logic [gfb_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [gfb_pkg::WORD_WIDTH-1:0]     csr_data
);
   import gfb_pkg::*;

   key_array_type            keys;
   logic [ROUND_COUNT:0]     chain_valid;
   logic [ROUND_COUNT:0]     chain_ready;
   stage_type                chain_data [0:ROUND_COUNT];

   gfb_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .keys      (keys)
   );

   assign chain_valid[0]      = req_valid;
   assign req_ready           = chain_ready[0];
   assign chain_data[0].mode  = req_mode;
   assign chain_data[0].left  = req_block_in[BLOCK_WIDTH-1:WORD_WIDTH];
   assign chain_data[0].right = req_block_in[WORD_WIDTH-1:0];

   for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
      // Encrypt: k0..k7 three times, then k7..k0. Decrypt: k0..k7 once, then k7..k0.
      localparam int ENC_IDX = (g < FORWARD_ROUNDS) ? (g % KEY_COUNT)
                                                    : (KEY_COUNT - 1 - (g % KEY_COUNT));
      localparam int DEC_IDX = (g < KEY_COUNT) ? (g % KEY_COUNT)
                                               : (KEY_COUNT - 1 - (g % KEY_COUNT));

      gfb_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .enc_key   (keys[KEY_IDX_WIDTH'(ENC_IDX)]),
         .dec_key   (keys[KEY_IDX_WIDTH'(DEC_IDX)]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   assign chain_ready[ROUND_COUNT] = rsp_ready;
   assign rsp_valid                = chain_valid[ROUND_COUNT];
   assign rsp_block_out            = {chain_data[ROUND_COUNT].left,
                                      chain_data[ROUND_COUNT].right};

endmodule
